[design/bap_pkg.sv]
// Shared types and constants for the 2x2 block-average pixelation block.
// No dependencies; imported by every module of the block.
`default_nettype none

package bap_pkg;

    localparam int MAX_WIDTH_DEF = 512;   // default depth of the line store
    localparam int MAX_HEIGHT    = 512;   // rows per frame at most
    localparam int CFG_W         = 10;    // width of a configuration register
    localparam int PIX_W         = 8;
    localparam int POS_W         = 9;     // row and column fields of a result
    localparam int SUM_W         = PIX_W + 2;
    localparam int FIFO_DEPTH    = 4;

    // Configuration register indexes
    typedef logic [0:0] cfg_index_t;
    localparam cfg_index_t REG_FRAME_WIDTH  = 1'b0;
    localparam cfg_index_t REG_FRAME_HEIGHT = 1'b1;

    // One finished block, handed from the front to the result stage
    typedef struct packed {
        logic [POS_W-1:0] row0;       // top row of the block
        logic [POS_W-1:0] col0;       // left column of the block
        logic             two_rows;
        logic             two_cols;
        logic [PIX_W-1:0] avg;
        logic             frame_done;
    } job_t;

endpackage

`default_nettype wire

[design/block_average_pixelate.sv]
// Top level of the 2x2 block-average pixelation block.
// Depends on bap_pkg, bap_front, bap_fifo and bap_emit.
//
//  channel  direction  handshake           payload
//  s_       in         s_valid / s_ready   s_pixel
//  m_       out        m_valid / m_ready   m_out_row, m_out_col, m_value, m_last,
//                                          m_frame_done
//  cfg_     in         cfg_wr_en           cfg_index, cfg_wdata
//
//  One pixel is taken per cycle while the block queue has room; the result
//  stage gives one result per cycle while m_ready is high, and odd rows
//  carry two results per pixel. A block's final pixel is registered in the
//  front stage, then queued, then loaded into the result register.
//  aresetn is synchronous and active low; it clears counters and queue, while
//  the line store holds whatever it held until its row is written again.
//  A stalled m_ side fills the four-entry queue before s_ready drops.
`default_nettype none

module block_average_pixelate
    import bap_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    // configuration writes
    input  wire logic             cfg_wr_en,
    input  wire cfg_index_t       cfg_index,
    input  wire logic [CFG_W-1:0] cfg_wdata,
    // pixels in raster order
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [PIX_W-1:0] s_pixel,
    // averaged pixels
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [POS_W-1:0]      m_out_row,
    output logic [POS_W-1:0]      m_out_col,
    output logic [PIX_W-1:0]      m_value,
    output logic                  m_last,
    output logic                  m_frame_done
);

    // finished blocks leaving the front end
    logic push_valid;
    logic push_ready;
    job_t push_data;

    // blocks waiting for the result stage
    logic pop_valid;
    logic pop;
    job_t pop_data;

    // Classify each pixel, keep even rows and average a block on its last pixel
    bap_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_pixel   (s_pixel),
        .job_valid (push_valid),
        .job_ready (push_ready),
        .job       (push_data)
    );

    // Decouple the two sides so each can stall on its own
    bap_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_data   (pop_data)
    );

    // Expand each block into one result per pixel, row-major
    bap_emit u_emit (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .job_valid    (pop_valid),
        .job_pop      (pop),
        .job          (pop_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_row    (m_out_row),
        .m_out_col    (m_out_col),
        .m_value      (m_value),
        .m_last       (m_last),
        .m_frame_done (m_frame_done)
    );

endmodule

`default_nettype wire

[design/bap_front.sv]
// Front end: configuration, raster counters, line store and block averaging.
// Depends on bap_pkg; pushes finished blocks as job_t items into bap_fifo.
`default_nettype none

module bap_front
    import bap_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_wr_en,
    input  wire cfg_index_t       cfg_index,
    input  wire logic [CFG_W-1:0] cfg_wdata,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [PIX_W-1:0] s_pixel,
    output logic                  job_valid,
    input  wire logic             job_ready,
    output job_t                  job
);

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int W_RESET = (MAX_WIDTH < 512) ? MAX_WIDTH : 512;

    typedef struct packed {
        logic [PIX_W-1:0] px;
        logic [PIX_W-1:0] left;
        logic             col_odd;
        logic             row_odd;
        logic             complete;
        logic [POS_W-1:0] row0;
        logic [POS_W-1:0] col0;
        logic             frame_done;
    } st1_t;

    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic [POS_W-1:0] row_reg;
    logic [COL_W-1:0] col_reg;
    logic [PIX_W-1:0] left_reg;
    logic [PIX_W-1:0] upper_left_reg;
    logic [PIX_W-1:0] rd_reg;
    logic [PIX_W-1:0] line_mem [MAX_WIDTH];
    logic             st1_valid_reg;
    st1_t             st1_reg;
    st1_t             st1_next;

    logic             accept;
    logic             st1_go;
    logic             col_last;
    logic             row_last;
    logic [POS_W-1:0] col9;
    logic [SUM_W-1:0] sum;
    logic [1:0]       shift;

    // Configuration, clamped on the way in
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= CFG_W'(W_RESET);
            height_reg <= CFG_W'(MAX_HEIGHT);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_FRAME_WIDTH: begin
                    if (cfg_wdata == '0) begin
                        width_reg <= CFG_W'(1);
                    end else if (int'(cfg_wdata) > MAX_WIDTH) begin
                        width_reg <= CFG_W'(MAX_WIDTH);
                    end else begin
                        width_reg <= cfg_wdata;
                    end
                end
                REG_FRAME_HEIGHT: begin
                    if (cfg_wdata == '0) begin
                        height_reg <= CFG_W'(1);
                    end else if (int'(cfg_wdata) > MAX_HEIGHT) begin
                        height_reg <= CFG_W'(MAX_HEIGHT);
                    end else begin
                        height_reg <= cfg_wdata;
                    end
                end
            endcase
        end
    end

    assign col_last = (int'(col_reg) + 1 >= int'(width_reg));
    assign row_last = (int'(row_reg) + 1 >= int'(height_reg));
    assign col9     = POS_W'(col_reg);

    assign st1_go  = !(st1_valid_reg && st1_reg.complete) || job_ready;
    assign s_ready = !st1_valid_reg || st1_go;
    assign accept  = s_valid && s_ready;

    always_comb begin
        st1_next.px         = s_pixel;
        st1_next.left       = left_reg;
        st1_next.col_odd    = col_reg[0];
        st1_next.row_odd    = row_reg[0];
        st1_next.complete   = (col_reg[0] || col_last) && (row_reg[0] || row_last);
        st1_next.row0       = {row_reg[POS_W-1:1], 1'b0};
        st1_next.col0       = {col9[POS_W-1:1], 1'b0};
        st1_next.frame_done = row_last && col_last;
    end

    // Raster position and the last pixel seen at an even column
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg  <= '0;
            col_reg  <= '0;
            left_reg <= '0;
        end else if (accept) begin
            if (!col_reg[0]) begin
                left_reg <= s_pixel;
            end
            if (col_last) begin
                col_reg <= '0;
                row_reg <= row_last ? '0 : row_reg + 1'b1;
            end else begin
                col_reg <= col_reg + 1'b1;
            end
        end
    end

    // Line store: write on even rows, registered read of the same column
    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_reg <= line_mem[col_reg];
            if (!row_reg[0]) begin
                line_mem[col_reg] <= s_pixel;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
        end else if (accept) begin
            st1_valid_reg <= 1'b1;
        end else if (st1_go) begin
            st1_valid_reg <= 1'b0;
        end
    end

    // Keep the upper pixel of an even column for its odd partner
    always_ff @(posedge aclk) begin
        if (accept) begin
            st1_reg <= st1_next;
        end
        if (st1_valid_reg && st1_go && !st1_reg.col_odd) begin
            upper_left_reg <= rd_reg;
        end
    end

    always_comb begin
        sum = SUM_W'(st1_reg.px);
        if (st1_reg.col_odd) begin
            sum = sum + SUM_W'(st1_reg.left);
        end
        if (st1_reg.row_odd) begin
            sum = sum + SUM_W'(rd_reg);
        end
        if (st1_reg.row_odd && st1_reg.col_odd) begin
            sum = sum + SUM_W'(upper_left_reg);
        end
        shift = {1'b0, st1_reg.col_odd} + {1'b0, st1_reg.row_odd};
    end

    assign job_valid      = st1_valid_reg && st1_reg.complete;
    assign job.row0       = st1_reg.row0;
    assign job.col0       = st1_reg.col0;
    assign job.two_rows   = st1_reg.row_odd;
    assign job.two_cols   = st1_reg.col_odd;
    assign job.avg        = PIX_W'(sum >> shift);
    assign job.frame_done = st1_reg.frame_done;

    // A stalled block holds its place until the queue takes it
    a_st1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        st1_valid_reg && !st1_go |=> st1_valid_reg && $stable(st1_reg))
        else $error("front stage lost a stalled block");

endmodule

`default_nettype wire

[design/bap_fifo.sv]
// Short queue of finished blocks between the front end and the result stage.
// Depends on bap_pkg for job_t and FIFO_DEPTH.
`default_nettype none

module bap_fifo
    import bap_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push_valid,
    output logic      push_ready,
    input  wire job_t push_data,
    output logic      pop_valid,
    input  wire logic pop,
    output job_t      pop_data
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    job_t             slot_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(FIFO_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;
    assign pop_data   = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(FIFO_DEPTH))
        else $error("queue count beyond depth");

    a_fill_to_full: assert property (@(posedge aclk) disable iff (!aresetn)
        do_push && !do_pop && count_reg == CNT_W'(FIFO_DEPTH - 1) |=> !push_ready)
        else $error("queue not full after its last free slot was taken");

endmodule

`default_nettype wire

[design/bap_emit.sv]
// Result stage: expands one queued block into one result per pixel.
// Depends on bap_pkg for job_t and field widths.
`default_nettype none

module bap_emit
    import bap_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              job_valid,
    output logic                   job_pop,
    input  wire job_t              job,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [POS_W-1:0]       m_out_row,
    output logic [POS_W-1:0]       m_out_col,
    output logic [PIX_W-1:0]       m_value,
    output logic                   m_last,
    output logic                   m_frame_done
);

    job_t cur_reg;
    logic cur_valid_reg;
    logic i_reg;
    logic j_reg;
    logic load;
    logic take;

    assign m_last       = (i_reg == cur_reg.two_rows) && (j_reg == cur_reg.two_cols);
    assign take         = cur_valid_reg && m_ready;
    assign load         = !cur_valid_reg || (m_ready && m_last);
    assign job_pop      = load && job_valid;

    assign m_valid      = cur_valid_reg;
    assign m_out_row    = {cur_reg.row0[POS_W-1:1], i_reg};
    assign m_out_col    = {cur_reg.col0[POS_W-1:1], j_reg};
    assign m_value      = cur_reg.avg;
    assign m_frame_done = cur_reg.frame_done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            i_reg         <= 1'b0;
            j_reg         <= 1'b0;
        end else if (load) begin
            cur_valid_reg <= job_valid;
            i_reg         <= 1'b0;
            j_reg         <= 1'b0;
        end else if (take) begin
            // row-major walk inside the block
            if (cur_reg.two_cols && !j_reg) begin
                j_reg <= 1'b1;
            end else begin
                j_reg <= 1'b0;
                i_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load && job_valid) begin
            cur_reg <= job;
        end
    end

    a_block_unbroken: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last |=> m_valid && $stable(cur_reg))
        else $error("block left before its last result");

endmodule

`default_nettype wire

[dv/block_average_pixelate_tb.sv]
// Self-checking testbench for block_average_pixelate, the 2x2 block-average pixelation block.
// Depends on bap_pkg and the block's RTL; it predicts every averaged pixel itself.
`default_nettype none

module block_average_pixelate_tb;
    import bap_pkg::*;

    // One averaged pixel as the block should hand it out
    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic [PIX_W-1:0] value;
        logic             last;
        logic             frame_done;
    } avg_pixel_t;

    // How the pixels of a frame are chosen
    typedef enum logic [1:0] {
        FILL_ZERO,
        FILL_FULL,
        FILL_EXTREME,
        FILL_RANDOM
    } fill_t;

    localparam int SETTLE_CYCLES = 12;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             cfg_wr_en = 1'b0;
    cfg_index_t       cfg_index = REG_FRAME_WIDTH;
    logic [CFG_W-1:0] cfg_wdata = '0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    logic [PIX_W-1:0] s_pixel = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic [POS_W-1:0] m_out_row;
    logic [POS_W-1:0] m_out_col;
    logic [PIX_W-1:0] m_value;
    logic             m_last;
    logic             m_frame_done;

    // Shadow of the block: sizes, raster position, line store and left pixel
    logic [CFG_W-1:0] width_reg = CFG_W'(512);
    logic [CFG_W-1:0] height_reg = CFG_W'(512);
    int unsigned      row_pos = 0;
    int unsigned      col_pos = 0;
    logic [PIX_W-1:0] line_store [MAX_WIDTH_DEF];
    logic [PIX_W-1:0] left_px = '0;

    avg_pixel_t       pending_pixels [$];
    bit               calm = 1'b0;    // no idling on either side while set
    int unsigned      pixels_sent = 0;
    int unsigned      pixels_checked = 0;
    int unsigned      frames_closed = 0;
    int unsigned      mismatches = 0;

    block_average_pixelate dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_pixel      (s_pixel),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_row    (m_out_row),
        .m_out_col    (m_out_col),
        .m_value      (m_value),
        .m_last       (m_last),
        .m_frame_done (m_frame_done)
    );

    always #5 aclk = ~aclk;

    // A size of zero counts as one; anything above the limit is held at the limit.
    function automatic int unsigned size_limit(input logic [CFG_W-1:0] v, input int unsigned hi);
        if (v == '0) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // Advance the shadow by one pixel and queue the averaged pixels of any block it completes.
    task automatic pixelate_step(input logic [PIX_W-1:0] px);
        int unsigned w, h, r, c, r0, c0, sum, cnt, total, n;
        bit          col_last, row_last, col_odd, row_odd;
        logic [PIX_W-1:0] avg;
        avg_pixel_t  res;
        w = size_limit(width_reg, MAX_WIDTH_DEF);
        h = size_limit(height_reg, MAX_HEIGHT);
        r = row_pos;
        c = col_pos;
        col_last = (c + 1 >= w);
        row_last = (r + 1 >= h);
        col_odd = c[0];
        row_odd = r[0];
        if ((col_odd || col_last) && (row_odd || row_last)) begin
            r0 = r & ~32'd1;
            c0 = c & ~32'd1;
            sum = px;
            cnt = 1;
            if (col_odd) begin
                sum += left_px;
                cnt++;
            end
            // the upper half of the block comes out of the line store
            if (row_odd) begin
                sum += line_store[c];
                cnt++;
                if (col_odd) begin
                    sum += line_store[c0];
                    cnt++;
                end
            end
            // divisor is 1, 2 or 4, so the average is a plain shift
            avg = PIX_W'(sum >> ((cnt == 4) ? 2 : (cnt == 2) ? 1 : 0));
            total = cnt;
            n = 0;
            for (int unsigned i = r0; i <= r; i++) begin
                for (int unsigned j = c0; j <= c; j++) begin
                    n++;
                    res.row = POS_W'(i);
                    res.col = POS_W'(j);
                    res.value = avg;
                    res.last = (n == total);
                    res.frame_done = row_last && col_last;
                    pending_pixels.push_back(res);
                end
            end
        end
        if (!row_odd) line_store[c] = px;
        if (!col_odd) left_px = px;
        if (col_last) begin
            col_pos = 0;
            row_pos = row_last ? 0 : ((r + 1) & 32'h3FF);
        end else begin
            col_pos = c + 1;
        end
    endtask

    // Offer one pixel, idling at random first, and hold it until the block takes it.
    task automatic send_pixel(input logic [PIX_W-1:0] px);
        @(negedge aclk);
        while (!calm && $urandom_range(99) < 24) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_pixel <= px;
        do @(posedge aclk); while (!s_ready);
        pixelate_step(px);
        pixels_sent++;
    endtask

    // Drop valid, wait for every queued average, then let the pipeline settle.
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_size(input cfg_index_t idx, input logic [CFG_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_FRAME_WIDTH) width_reg = val;
        else height_reg = val;
    endtask

    function automatic logic [PIX_W-1:0] pick_pixel(input fill_t fill);
        case (fill)
            FILL_ZERO:    return '0;
            FILL_FULL:    return '1;
            FILL_EXTREME: return $urandom_range(1) ? '1 : '0;
            default:      return PIX_W'($urandom_range(255));
        endcase
    endfunction

    // Set both sizes, send one whole frame and wait for all of its averages.
    task automatic send_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                              input fill_t fill);
        int unsigned count;
        write_size(REG_FRAME_WIDTH, w);
        write_size(REG_FRAME_HEIGHT, h);
        count = size_limit(w, MAX_WIDTH_DEF) * size_limit(h, MAX_HEIGHT);
        repeat (count) send_pixel(pick_pixel(fill));
        drain_results();
    endtask

    // Start under the reset sizes, then shrink both in the middle of the frame:
    // the counters carry on and the position past the new width wraps at once.
    task automatic test_reset_sizes();
        repeat (4) send_pixel(pick_pixel(FILL_RANDOM));
        drain_results();
        write_size(REG_FRAME_WIDTH, CFG_W'(4));
        write_size(REG_FRAME_HEIGHT, CFG_W'(2));
        repeat (5) send_pixel(pick_pixel(FILL_RANDOM));
        drain_results();
    endtask

    // Full, edge-cut and single-pixel blocks with extreme grey levels.
    task automatic test_block_shapes();
        send_frame(CFG_W'(2), CFG_W'(2), FILL_FULL);
        send_frame(CFG_W'(3), CFG_W'(3), FILL_EXTREME);
    endtask

    // Zero sizes behave as one: every pixel is a frame of its own.
    task automatic test_zero_sizes();
        write_size(REG_FRAME_WIDTH, '0);
        write_size(REG_FRAME_HEIGHT, '0);
        send_pixel(pick_pixel(FILL_ZERO));
        send_pixel(pick_pixel(FILL_RANDOM));
        drain_results();
    endtask

    // Oversized registers saturate; run into the first row, then shrink both sizes
    // so the position past the new width wraps and the next row closes the frame.
    task automatic test_largest_sizes();
        write_size(REG_FRAME_WIDTH, '1);
        write_size(REG_FRAME_HEIGHT, '1);
        repeat (8) send_pixel(pick_pixel(FILL_RANDOM));
        drain_results();
        write_size(REG_FRAME_WIDTH, CFG_W'(2));
        write_size(REG_FRAME_HEIGHT, CFG_W'(2));
        repeat (3) send_pixel(pick_pixel(FILL_RANDOM));
        drain_results();
    endtask

    // Whole frames of random small sizes and random pixels.
    task automatic test_random_frames();
        int unsigned first;
        first = pixels_sent;
        while (pixels_sent - first < 230) begin
            calm = (pixels_sent - first >= 80) && (pixels_sent - first < 160);
            send_frame(CFG_W'($urandom_range(12)), CFG_W'($urandom_range(7)), FILL_RANDOM);
        end
        calm = 1'b0;
    endtask

    // Result side stalls at random, except while the run is kept calm.
    always @(negedge aclk) begin
        m_ready <= calm || ($urandom_range(99) >= 24);
    end

    // Compare each averaged pixel taken with the oldest one predicted.
    always @(posedge aclk) begin
        avg_pixel_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_pixels.size() == 0) begin
                $error("unexpected averaged pixel at row %0d col %0d", m_out_row, m_out_col);
                mismatches++;
            end else begin
                want = pending_pixels.pop_front();
                pixels_checked++;
                if (m_last && m_frame_done) frames_closed++;
                if (m_out_row !== want.row) begin
                    $error("out_row: expected %0d, got %0d", want.row, m_out_row);
                    mismatches++;
                end
                if (m_out_col !== want.col) begin
                    $error("out_col: expected %0d, got %0d", want.col, m_out_col);
                    mismatches++;
                end
                if (m_value !== want.value) begin
                    $error("value: expected %0d, got %0d", want.value, m_value);
                    mismatches++;
                end
                if (m_last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, m_last);
                    mismatches++;
                end
                if (m_frame_done !== want.frame_done) begin
                    $error("frame_done: expected %0d, got %0d", want.frame_done, m_frame_done);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        test_reset_sizes();
        test_block_shapes();
        test_zero_sizes();
        test_largest_sizes();
        test_random_frames();
        drain_results();
        if (pending_pixels.size() != 0) begin
            $error("%0d averaged pixels never arrived", pending_pixels.size());
            mismatches++;
        end
        $display("Sent %0d pixels over frames from 1x1 up to 12x7, saturated sizes",
                 pixels_sent);
        $display("and sizes shrunk mid-frame; checked %0d averaged pixels and %0d frame ends.",
                 pixels_checked, frames_closed);
        if (mismatches == 0) begin
            $display("block_average_pixelate_tb OK");
        end else begin
            $display("block_average_pixelate_tb NOT OK");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #20000000;
        $display("block_average_pixelate_tb NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
